### design/bpwa_pkg.sv
// ----------------------------------------------------------------------------
// bpwa_pkg
// Shared types and constants of the block pair weight accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpwa_pkg;

  // Default sizes of the membership store
  localparam int MAX_NODES_DEF    = 1024;
  localparam int MAX_CLUSTERS_DEF = 16;

  // Field widths
  localparam int ROW_W    = 4;
  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int EDGE_W   = 24;
  localparam int RES_W    = 26;
  localparam int TOTAL_W  = 32;
  localparam int SUM_W    = 48;
  localparam int FRAC_W   = 15;
  localparam int WSUM_W   = 17;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [WEIGHT_W-1:0] ONE_Q15 = WEIGHT_W'(32768);

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_PAIR = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLUSTER_FIRST  = 2'd0,
    REG_CLUSTER_SECOND = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_DATA,
    S_ACC,
    S_EDGE,
    S_RES,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

### design/bpwa_ram.sv
// ----------------------------------------------------------------------------
// bpwa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### design/block_pair_weight_accumulator.sv
// ----------------------------------------------------------------------------
// block_pair_weight_accumulator
// Membership weight store with a sequenced pair-weight multiply-accumulate.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid_i/tready_o    tdata, tuser=opcode, tlast=last_pair
//  m_axis    out  m_axis_tvalid_o/tready_i    tdata, tlast=is_last
//  cfg       in   cfg_we_i                    cfg_idx_i, cfg_data_i
//
// A load beat is written to the store in the cycle it is accepted when its
// row and node are in range. A pair beat holds off ready until its result
// turns valid: each store read takes an ADDR and a DATA state on the single
// read port (four reads with two clusters, two with one), then the one shared
// multiplier forms the pair weight, its product with the edge value, then
// the sum and total are updated before the result is registered.
// A finished result waits in the output register; the block stalls there
// only when an earlier result is still untaken. Reset clears control state,
// configuration and the running sum; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module block_pair_weight_accumulator #(
  parameter int MAX_NODES    = bpwa_pkg::MAX_NODES_DEF,
  parameter int MAX_CLUSTERS = bpwa_pkg::MAX_CLUSTERS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // cluster_row[3:0], node_first[13:4], node_second[23:14],
  // weight_value[39:24], edge_value[63:40]
  input  wire logic [bpwa_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // opcode[0]
  input  wire logic                               s_axis_tuser_i,
  input  wire logic                               s_axis_tlast_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // pair_result[25:0], total_count[57:26], zero[63:58]
  output logic [bpwa_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  output logic                                    m_axis_tlast_o,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [bpwa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bpwa_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int DEPTH = MAX_CLUSTERS * MAX_NODES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int ROW_W    = bpwa_pkg::ROW_W;
  localparam int NODE_W   = bpwa_pkg::NODE_W;
  localparam int WEIGHT_W = bpwa_pkg::WEIGHT_W;
  localparam int EDGE_W   = bpwa_pkg::EDGE_W;
  localparam int RES_W    = bpwa_pkg::RES_W;
  localparam int TOTAL_W  = bpwa_pkg::TOTAL_W;
  localparam int SUM_W    = bpwa_pkg::SUM_W;
  localparam int FRAC_W   = bpwa_pkg::FRAC_W;
  localparam int WSUM_W   = bpwa_pkg::WSUM_W;
  localparam int MUL_A_W  = bpwa_pkg::MUL_A_W;
  localparam int MUL_B_W  = bpwa_pkg::MUL_B_W;
  localparam int MUL_P_W  = bpwa_pkg::MUL_P_W;

  localparam logic signed [MUL_P_W-1:0] P_BIAS   = MUL_P_W'((1 << FRAC_W) - 1);
  localparam logic signed [SUM_W-1:0]   S_BIAS   = SUM_W'((1 << FRAC_W) - 1);
  localparam logic signed [SUM_W-1:0]   SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]   SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [TOTAL_W-1:0]        TOT_MAX  = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic [TOTAL_W-1:0]        TOT_MIN  = {1'b1, {(TOTAL_W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Input field unpacking
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]           in_row;
  logic [NODE_W-1:0]          in_node_a;
  logic [NODE_W-1:0]          in_node_b;
  logic [WEIGHT_W-1:0]        in_weight;
  logic signed [EDGE_W-1:0]   in_edge;
  logic                       in_accept;

  assign in_row    = s_axis_tdata_i[3:0];
  assign in_node_a = s_axis_tdata_i[13:4];
  assign in_node_b = s_axis_tdata_i[23:14];
  assign in_weight = s_axis_tdata_i[39:24];
  assign in_edge   = s_axis_tdata_i[63:40];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  function automatic logic in_range(logic [ROW_W-1:0] row, logic [NODE_W-1:0] node);
    return (32'(row) < 32'(MAX_CLUSTERS)) && (32'(node) < 32'(MAX_NODES));
  endfunction

  function automatic logic [AW-1:0] store_addr(logic [ROW_W-1:0] row,
                                               logic [NODE_W-1:0] node);
    return AW'(32'(row) * 32'(MAX_NODES) + 32'(node));
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] cl_first_q;
  logic [ROW_W-1:0] cl_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_first_q  <= '0;
      cl_second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpwa_pkg::REG_CLUSTER_FIRST:  cl_first_q  <= cfg_data_i;
        bpwa_pkg::REG_CLUSTER_SECOND: cl_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Membership store
  // --------------------------------------------------------------------------
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WEIGHT_W-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WEIGHT_W-1:0] ram_rdata;

  // Write an in-range load beat straight away, clamped to one
  assign ram_we    = in_accept && (s_axis_tuser_i == bpwa_pkg::OP_LOAD)
                     && in_range(in_row, in_node_a);
  assign ram_waddr = store_addr(in_row, in_node_a);
  assign ram_wdata = (in_weight > bpwa_pkg::ONE_Q15) ? bpwa_pkg::ONE_Q15 : in_weight;

  bpwa_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  bpwa_pkg::state_e state_q, state_d;
  logic [1:0]       step_q, step_d;
  logic             last_step;
  logic             out_free;
  logic             out_load;

  logic [NODE_W-1:0]        node_a_q;
  logic [NODE_W-1:0]        node_b_q;
  logic signed [EDGE_W-1:0] edge_q;
  logic                     last_q;

  logic [ROW_W-1:0]  rd_row;
  logic [NODE_W-1:0] rd_node;
  logic              rd_ok_q;

  // Step order: (k,a) (l,b) then (k,b) (l,a); one cluster stops after two
  assign last_step = (cl_first_q == cl_second_q) ? (step_q == 2'd1) : (step_q == 2'd3);
  assign out_free  = !m_axis_tvalid_o || m_axis_tready_i;

  always_comb begin
    rd_row  = step_q[0] ? cl_second_q : cl_first_q;
    rd_node = (step_q == 2'd0 || step_q == 2'd3) ? node_a_q : node_b_q;
  end

  assign ram_raddr = store_addr(rd_row, rd_node);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpwa_pkg::S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      bpwa_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && (s_axis_tuser_i == bpwa_pkg::OP_PAIR)) begin
          state_d = bpwa_pkg::S_ADDR;
          step_d  = '0;
        end
      end
      bpwa_pkg::S_ADDR: state_d = bpwa_pkg::S_DATA;
      bpwa_pkg::S_DATA: begin
        if (step_q[0]) begin
          state_d = bpwa_pkg::S_ACC;
        end else begin
          state_d = bpwa_pkg::S_ADDR;
          step_d  = step_q + 2'd1;
        end
      end
      bpwa_pkg::S_ACC: begin
        if (last_step) begin
          state_d = bpwa_pkg::S_EDGE;
        end else begin
          state_d = bpwa_pkg::S_ADDR;
          step_d  = step_q + 2'd1;
        end
      end
      bpwa_pkg::S_EDGE: state_d = bpwa_pkg::S_RES;
      bpwa_pkg::S_RES:  state_d = bpwa_pkg::S_FIN;
      bpwa_pkg::S_FIN: begin
        // hold until the output register frees up
        if (out_free) begin
          out_load = 1'b1;
          state_d  = bpwa_pkg::S_IDLE;
        end
      end
      default: state_d = bpwa_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and datapath
  // --------------------------------------------------------------------------
  logic [WEIGHT_W-1:0]        opa_q;
  logic [WEIGHT_W-1:0]        rd_weight;
  logic [WSUM_W-1:0]          wsum_q;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [MUL_P_W-1:0]  prod_q;
  logic signed [MUL_P_W-1:0]  prod_rnd;
  logic signed [RES_W-1:0]    res_q;
  logic signed [RES_W-1:0]    res_d;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [SUM_W:0]      sum_ext;
  logic signed [SUM_W-1:0]    sum_sat;
  logic signed [SUM_W-1:0]    sum_rnd;
  logic [TOTAL_W:0]           quot;
  logic [TOTAL_W-1:0]         total_d;

  assign rd_weight = rd_ok_q ? ram_rdata : '0;

  always_comb begin
    if (state_q == bpwa_pkg::S_EDGE) begin
      mul_a = MUL_A_W'(wsum_q);
      mul_b = edge_q;
    end else begin
      mul_a = MUL_A_W'(opa_q);
      mul_b = MUL_B_W'(rd_weight);
    end
  end

  assign mul_p = mul_a * mul_b;

  // Divide by 2^15 rounding toward zero
  assign prod_rnd = prod_q + (prod_q[MUL_P_W-1] ? P_BIAS : '0);
  assign res_d    = prod_rnd[FRAC_W+RES_W-1:FRAC_W];

  // Accumulate the result being registered in this cycle
  assign sum_ext = {sum_q[SUM_W-1], sum_q} + (SUM_W+1)'(res_d);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  assign sum_rnd = sum_q + (sum_q[SUM_W-1] ? S_BIAS : '0);
  assign quot    = sum_rnd[FRAC_W+TOTAL_W:FRAC_W];
  always_comb begin
    if (quot[TOTAL_W] != quot[TOTAL_W-1]) begin
      total_d = quot[TOTAL_W] ? TOT_MIN : TOT_MAX;
    end else begin
      total_d = quot[TOTAL_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      node_a_q <= in_node_a;
      node_b_q <= in_node_b;
      edge_q   <= in_edge;
      last_q   <= s_axis_tlast_i;
      wsum_q   <= '0;
    end
    if (state_q == bpwa_pkg::S_ADDR) begin
      rd_ok_q <= in_range(rd_row, rd_node);
    end
    if (state_q == bpwa_pkg::S_DATA) begin
      if (step_q[0]) begin
        prod_q <= mul_p;
      end else begin
        opa_q <= rd_weight;
      end
    end
    if (state_q == bpwa_pkg::S_ACC) begin
      wsum_q <= wsum_q + WSUM_W'(prod_q[FRAC_W+WEIGHT_W-1:FRAC_W]);
    end
    if (state_q == bpwa_pkg::S_EDGE) begin
      prod_q <= mul_p;
    end
    if (state_q == bpwa_pkg::S_RES) begin
      res_q <= res_d;
    end
  end

  // Running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (state_q == bpwa_pkg::S_RES) begin
      sum_q <= sum_sat;
    end else if (out_load && last_q) begin
      sum_q <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                    out_valid_q;
  logic signed [RES_W-1:0] out_res_q;
  logic [TOTAL_W-1:0]      out_total_q;
  logic                    out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q   <= res_q;
      out_total_q <= last_q ? total_d : '0;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {(bpwa_pkg::OUT_TDATA_W-RES_W-TOTAL_W)'(0), out_total_q, out_res_q};

endmodule

`default_nettype wire
